// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the ICMP echo responder RTL.
// Expects clk and arst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ICMP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ICMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/icmp_pkg.sv =====
// Package for the ICMP echo responder: item types, verdict codes, word positions
// and the one's-complement adder. No dependencies.
`default_nettype none

package icmp_pkg;

	typedef enum logic [2:0] {
		VERDICT_NONE      = 3'd0,
		VERDICT_SEND      = 3'd1,
		VERDICT_TOO_SHORT = 3'd2,
		VERDICT_BAD_CODE  = 3'd3,
		VERDICT_BAD_CSUM  = 3'd4,
		VERDICT_NOT_ECHO  = 3'd5
	} verdict_e_t;

	typedef logic [2:0] word_pos_t;

	localparam word_pos_t POS_TYPE    = 3'd0;
	localparam word_pos_t POS_CSUM    = 3'd1;
	localparam word_pos_t POS_SEQ     = 3'd3;
	localparam word_pos_t POS_PAYLOAD = 3'd4;

	localparam logic [7:0] ECHO_REQUEST_TYPE = 8'd8;

	typedef struct packed {
		logic [15:0] data_word;
		logic        odd_tail;
		logic        last_word;
		logic [31:0] source_addr;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_word;
		logic        out_odd_tail;
		logic        out_last;
		logic [31:0] dest_addr;
		verdict_e_t  verdict;
	} out_item_t;

	// Input register contents handed to the engine.
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} stage_t;

	// 16-bit one's-complement add with end-around carry.
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		logic [16:0] f;
		s = {1'b0, a} + {1'b0, b};
		f = {1'b0, s[15:0]} + {16'd0, s[16]};
		return f[15:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/icmp_if.sv =====
// Valid/ready stream interfaces for ICMP message words and reply words.
// Standalone; payload widths follow the message field definitions.
`default_nettype none

interface icmp_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] data_word;
	logic        odd_tail;
	logic        last_word;
	logic [31:0] source_addr;

	modport source (output valid, data_word, odd_tail, last_word, source_addr, input ready);
	modport sink   (input valid, data_word, odd_tail, last_word, source_addr, output ready);
endinterface

interface icmp_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_word;
	logic        out_odd_tail;
	logic        out_last;
	logic [31:0] dest_addr;
	logic [2:0]  verdict;

	modport source (output valid, out_word, out_odd_tail, out_last, dest_addr, verdict,
		input ready);
	modport sink   (input valid, out_word, out_odd_tail, out_last, dest_addr, verdict,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/icmp_ingress.sv =====
// Input register of the ICMP echo responder: captures one message word per transfer.
// Depends on icmp_pkg, icmp_if.sv and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module icmp_ingress (
	input  wire logic        clk,
	input  wire logic        arst_n,
	icmp_in_if.sink          request,
	input  wire logic        advance,
	output icmp_pkg::stage_t stage
);
	import icmp_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;

	// Free slot, or the held word moves on this cycle.
	assign request.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			item_s1 <= '{data_word:   request.data_word,
			             odd_tail:    request.odd_tail,
			             last_word:   request.last_word,
			             source_addr: request.source_addr};
		end
	end

	assign stage = '{valid: valid_s1, item: item_s1};

	`ICMP_ASSERT_NEXT(a_hold_s1, valid_s1 && !advance, valid_s1 && $stable(item_s1), "held word lost")

endmodule

`default_nettype wire

// ===== hw/rtl/icmp_engine.sv =====
// Message state, reply word rewrite, verdict and result register.
// Depends on icmp_pkg, icmp_if.sv and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module icmp_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  icmp_pkg::stage_t stage,
	output logic             advance,
	icmp_out_if.source       reply
);
	import icmp_pkg::*;

	word_pos_t   pos_q;
	logic [15:0] sum_q;
	logic [15:0] csum_q;
	logic [15:0] tc_q;
	logic [31:0] peer_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [15:0] w;
	logic [15:0] sum_new;
	logic [15:0] csum_new;
	logic [15:0] tc_new;
	logic [31:0] peer_new;
	logic [15:0] upd;
	logic [15:0] ow;
	logic        short_msg;
	word_pos_t   pos_next;
	verdict_e_t  verdict;

	assign advance = stage.valid && (!out_valid_q || reply.ready);

	always_comb begin
		w = stage.item.odd_tail ? {stage.item.data_word[15:8], 8'h00} : stage.item.data_word;
		// Incremental checksum update for the type byte going to zero.
		upd      = oc_add(oc_add(~w, ~tc_q), {8'h00, tc_q[7:0]});
		tc_new   = (pos_q == POS_TYPE) ? w : tc_q;
		csum_new = (pos_q == POS_CSUM) ? w : csum_q;
		peer_new = (pos_q == POS_TYPE) ? stage.item.source_addr : peer_q;
		sum_new  = (pos_q == POS_CSUM) ? sum_q : oc_add(sum_q, w);
		unique case (pos_q)
			POS_TYPE: ow = {8'h00, w[7:0]};
			POS_CSUM: ow = ~upd;
			default:  ow = w;
		endcase

		short_msg = (pos_q < POS_SEQ) || ((pos_q == POS_SEQ) && stage.item.odd_tail);
		if (!stage.item.last_word) begin
			verdict = VERDICT_NONE;
		end else if (short_msg) begin
			verdict = VERDICT_TOO_SHORT;
		end else if (tc_new[7:0] != 8'h00) begin
			verdict = VERDICT_BAD_CODE;
		end else if (~sum_new != csum_new) begin
			verdict = VERDICT_BAD_CSUM;
		end else if (tc_new[15:8] != ECHO_REQUEST_TYPE) begin
			verdict = VERDICT_NOT_ECHO;
		end else begin
			verdict = VERDICT_SEND;
		end

		if (stage.item.last_word) begin
			pos_next = POS_TYPE;
		end else if (pos_q < POS_PAYLOAD) begin
			pos_next = pos_q + 3'd1;
		end else begin
			pos_next = pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_TYPE;
			sum_q       <= '0;
			csum_q      <= '0;
			tc_q        <= '0;
			peer_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pos_q  <= pos_next;
				sum_q  <= stage.item.last_word ? 16'h0000 : sum_new;
				csum_q <= csum_new;
				tc_q   <= tc_new;
				peer_q <= peer_new;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (reply.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= '{out_word:     ow,
			           out_odd_tail: stage.item.odd_tail,
			           out_last:     stage.item.last_word,
			           dest_addr:    peer_new,
			           verdict:      verdict};
		end
	end

	assign reply.valid        = out_valid_q;
	assign reply.out_word     = out_q.out_word;
	assign reply.out_odd_tail = out_q.out_odd_tail;
	assign reply.out_last     = out_q.out_last;
	assign reply.dest_addr    = out_q.dest_addr;
	assign reply.verdict      = out_q.verdict;

	`ICMP_ASSERT_NOW(a_pos_range, 1'b1, pos_q <= POS_PAYLOAD, "word position out of range")
	`ICMP_ASSERT_NEXT(a_end_clear, advance && stage.item.last_word, pos_q == POS_TYPE && sum_q == 16'h0000, "state not cleared at end")
	`ICMP_ASSERT_NOW(a_mid_verdict, out_valid_q && !out_q.out_last, out_q.verdict == VERDICT_NONE, "verdict on mid-message word")

endmodule

`default_nettype wire

// ===== hw/rtl/icmp_echo_responder_top.sv =====
// Top level of the ICMP echo responder: input register plus reply engine.
// Depends on icmp_pkg, icmp_if.sv, icmp_ingress and icmp_engine.
`default_nettype none

// ICMP echo responder. Each transfer on request carries one 16-bit big-endian
// message word (first byte in the high half), an odd-tail mark, a last mark and
// the sender's IPv4 address, which is latched on the first word of a message.
// Every word yields exactly one reply word on reply: the type byte is cleared
// to zero (echo reply), the checksum word is patched incrementally for that
// change, and every other word is copied. A word with odd_tail set has its low
// byte forced to zero. dest_addr carries the latched sender address. On the
// last word, verdict says whether to send the reply (1) or why to drop it:
// 2 shorter than the 8-byte header, 3 nonzero code, 4 checksum mismatch,
// 5 type not echo request; precedence in that order. Mid-message words carry
// verdict 0. A message whose reply body is all zero gets checksum 0x0000 rather
// than 0xFFFF. Throughput is one transfer per clock while reply is ready; a word
// passes the input register, then the result register, with all checksum
// and verdict logic between them. request.ready depends combinationally on
// reply.ready through the input register's advance condition, so a stalled
// reply holds both registers and then backpressures the source.
module icmp_echo_responder_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	icmp_in_if.sink    request,
	icmp_out_if.source reply
);
	import icmp_pkg::*;

	stage_t stage;
	logic   advance;

	// Input word register; holds one transfer until the engine takes it.
	icmp_ingress u_ingress (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.advance (advance),
		.stage   (stage)
	);

	// Running sum, header capture, rewrite, verdict and the result register.
	icmp_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.stage   (stage),
		.advance (advance),
		.reply   (reply)
	);

endmodule

`default_nettype wire

// ===== tb/sv/icmp_echo_checker.sv =====
// Reply checker for the ICMP echo responder: watches both streams, predicts each
// reply word from the request words and compares field by field.
// Depends on icmp_pkg and the stream interfaces in icmp_if.sv.
`default_nettype none

module icmp_echo_checker (
	input  wire logic   clk,
	input  wire logic   arst_n,
	icmp_in_if          request,
	icmp_out_if         reply,
	output int unsigned fail_count,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import icmp_pkg::*;

	// Predictor state, mirrors the block's message tracking
	word_pos_t   msg_pos;
	logic [15:0] sum_acc;
	logic [15:0] got_csum;
	logic [15:0] head_word;
	logic [31:0] peer_ip;

	out_item_t   reply_q[$];
	int unsigned errors;
	int unsigned reply_idx;

	function automatic logic [15:0] csum_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	// Advance the message state by one word and form the reply word it yields.
	task automatic echo_predict(input in_item_t it, output out_item_t r);
		logic [15:0] w;
		logic [15:0] ow;
		logic [15:0] s;
		word_pos_t   pos;
		verdict_e_t  v;
		w = it.data_word;
		if (it.odd_tail) begin
			w[7:0] = 8'h00;
		end
		pos = msg_pos;
		if (pos == POS_TYPE) begin
			peer_ip   = it.source_addr;
			head_word = w;
			sum_acc   = csum_add(sum_acc, w);
			ow        = {8'h00, w[7:0]};
		end else if (pos == POS_CSUM) begin
			// incremental update for the type byte going to zero
			got_csum = w;
			s  = csum_add(~w, ~head_word);
			s  = csum_add(s, {8'h00, head_word[7:0]});
			ow = ~s;
		end else begin
			sum_acc = csum_add(sum_acc, w);
			ow      = w;
		end
		if (pos < POS_PAYLOAD) begin
			msg_pos = pos + 3'd1;
		end
		v = VERDICT_NONE;
		if (it.last_word) begin
			if (pos < POS_SEQ || (pos == POS_SEQ && it.odd_tail)) begin
				v = VERDICT_TOO_SHORT;
			end else if (head_word[7:0] != 8'h00) begin
				v = VERDICT_BAD_CODE;
			end else if (~sum_acc != got_csum) begin
				v = VERDICT_BAD_CSUM;
			end else if (head_word[15:8] != ECHO_REQUEST_TYPE) begin
				v = VERDICT_NOT_ECHO;
			end else begin
				v = VERDICT_SEND;
			end
			msg_pos = POS_TYPE;
			sum_acc = '0;
		end
		r.out_word     = ow;
		r.out_odd_tail = it.odd_tail;
		r.out_last     = it.last_word;
		r.dest_addr    = peer_ip;
		r.verdict      = v;
	endtask

	always @(posedge clk or negedge arst_n) begin
		in_item_t  it;
		out_item_t want;
		if (!arst_n) begin
			msg_pos     = POS_TYPE;
			sum_acc     = '0;
			got_csum    = '0;
			head_word   = '0;
			peer_ip     = '0;
			errors      = 0;
			reply_idx   = 0;
			reply_q.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			// compare before predicting: the block registers every word before its reply goes out
			if (reply.valid && reply.ready) begin
				if (reply_q.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("reply %0d: unexpected, got word=%h odd=%b last=%b dest=%h verdict=%0d",
							reply_idx, reply.out_word, reply.out_odd_tail, reply.out_last,
							reply.dest_addr, reply.verdict);
					end
				end else begin
					want = reply_q.pop_front();
					if (reply.out_word !== want.out_word || reply.out_odd_tail !== want.out_odd_tail
						|| reply.out_last !== want.out_last || reply.dest_addr !== want.dest_addr
						|| reply.verdict !== want.verdict) begin
						errors++;
						if (errors <= 10) begin
							$display("reply %0d: expected word=%h odd=%b last=%b dest=%h verdict=%0d",
								reply_idx, want.out_word, want.out_odd_tail, want.out_last,
								want.dest_addr, want.verdict);
							$display("reply %0d:      got word=%h odd=%b last=%b dest=%h verdict=%0d",
								reply_idx, reply.out_word, reply.out_odd_tail, reply.out_last,
								reply.dest_addr, reply.verdict);
						end
					end
				end
				reply_idx++;
			end
			if (request.valid && request.ready) begin
				it.data_word   = request.data_word;
				it.odd_tail    = request.odd_tail;
				it.last_word   = request.last_word;
				it.source_addr = request.source_addr;
				echo_predict(it, want);
				reply_q.push_back(want);
			end
			fail_count  <= errors;
			outstanding <= reply_q.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_icmp_echo_responder_top.sv =====
// Testbench top for the ICMP echo responder: clock, reset, message stimulus,
// reply backpressure and the final verdict.
// Depends on icmp_pkg, icmp_if.sv, icmp_echo_responder_top and icmp_echo_checker.
`default_nettype none

module tb_icmp_echo_responder_top;
	timeunit 1ns;
	timeprecision 1ps;

	import icmp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned WORD_TARGET = 1450;
	// the reply side goes quiet once this many words have gone in
	localparam int unsigned HOLD_AFTER  = 700;
	localparam int unsigned HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n;

	icmp_in_if  request_ch();
	icmp_out_if reply_ch();

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned words_sent = 0;
	int unsigned cycles = 0;
	logic        hold_reply = 1'b0;
	logic        burst_tx = 1'b0;

	// message under construction, sent as a whole by ship()
	in_item_t msg_q[$];

	icmp_echo_responder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request_ch),
		.reply  (reply_ch)
	);

	icmp_echo_checker echo_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.request    (request_ch),
		.reply      (reply_ch),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one word; idle a random number of cycles first unless in a burst.
	// valid is only lowered when there really is a gap, so back-to-back
	// transfers keep it high across the edge.
	task automatic send_word(input in_item_t it);
		int unsigned gap;
		gap = burst_tx ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			request_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_ch.valid       <= 1'b1;
		request_ch.data_word   <= it.data_word;
		request_ch.odd_tail    <= it.odd_tail;
		request_ch.last_word   <= it.last_word;
		request_ch.source_addr <= it.source_addr;
		@(posedge clk);
		while (!request_ch.ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic put(input logic [15:0] d, input logic odd, input logic [31:0] src);
		in_item_t it;
		it.data_word   = d;
		it.odd_tail    = odd;
		it.last_word   = 1'b0;
		it.source_addr = src;
		msg_q.push_back(it);
	endtask

	// Mark the last word, optionally fill in the checksum word (xor'd with flip
	// to corrupt it), then send the message. Odd tails count with a zero low byte.
	task automatic ship(input bit seal, input logic [15:0] flip);
		logic [31:0] acc;
		if (seal && msg_q.size() >= 2) begin
			acc = '0;
			foreach (msg_q[i])
				if (i != 1)
					acc += {16'd0, msg_q[i].odd_tail
						? {msg_q[i].data_word[15:8], 8'h00}
						: msg_q[i].data_word};
			acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
			acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
			msg_q[1].data_word = ~acc[15:0] ^ flip;
		end
		msg_q[msg_q.size() - 1].last_word = 1'b1;
		foreach (msg_q[i]) send_word(msg_q[i]);
		msg_q.delete();
		// occasionally run the next message with no idle cycles at all
		burst_tx = ($urandom_range(0, 5) == 0);
	endtask

	// Reply side: random stall per transfer, burst stretches every 40 transfers,
	// and the long hold-off when hold_reply is raised.
	initial begin : reply_sink
		int unsigned stall;
		int unsigned taken;
		logic        burst_rx;
		reply_ch.ready <= 1'b0;
		taken    = 0;
		burst_rx = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken % 40 == 0) begin
				burst_rx = ($urandom_range(0, 3) == 0);
			end
			stall = burst_rx ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				reply_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			while (hold_reply) begin
				reply_ch.ready <= 1'b0;
				@(posedge clk);
			end
			reply_ch.ready <= 1'b1;
			@(posedge clk);
			while (!reply_ch.valid) @(posedge clk);
			taken++;
		end
	end

	// Long hold-off on the reply side while requests keep coming; the two
	// register stages fill and request.ready has to drop.
	initial begin : reply_hold
		@(posedge clk);
		while (words_sent < HOLD_AFTER) @(posedge clk);
		hold_reply <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_reply <= 1'b0;
	end

	// Watchdog
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("icmp_echo_responder_top: mismatch");
		$finish;
	end

	initial begin : stimulus
		int unsigned kind;
		int unsigned plen;
		logic [7:0]  ty;
		logic [7:0]  cd;
		arst_n                 <= 1'b0;
		request_ch.valid       <= 1'b0;
		request_ch.data_word   <= '0;
		request_ch.odd_tail    <= 1'b0;
		request_ch.last_word   <= 1'b0;
		request_ch.source_addr <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed messages ---
		// good echo request, odd tail mid-header and at the end, all-ones fields
		put(16'h0800, 1'b0, '1);
		put(16'h0000, 1'b0, '1);
		put(16'h12FF, 1'b1, '1);
		put(16'hFFFF, 1'b0, '1);
		put(16'hFFFF, 1'b1, '1);
		ship(1'b1, 16'h0000);
		// single-word message, all-ones data, zero sender address: too short
		put(16'hFFFF, 1'b1, '0);
		ship(1'b0, 16'h0000);
		// header whose fourth word has an odd tail, only 7 bytes: too short
		put(16'h0800, 1'b0, $urandom());
		put(16'h0000, 1'b0, $urandom());
		put(16'($urandom()), 1'b0, $urandom());
		put(16'($urandom()), 1'b1, $urandom());
		ship(1'b1, 16'h0000);
		// nonzero code with a valid checksum
		put(16'h08FF, 1'b0, $urandom());
		put(16'h0000, 1'b0, $urandom());
		put(16'($urandom()), 1'b0, $urandom());
		put(16'($urandom()), 1'b0, $urandom());
		ship(1'b1, 16'h0000);
		// checksum off by one bit
		put(16'h0800, 1'b0, $urandom());
		put(16'h0000, 1'b0, $urandom());
		put(16'($urandom()), 1'b0, $urandom());
		put(16'($urandom()), 1'b0, $urandom());
		ship(1'b1, 16'h0001);
		// all-zero message: checksum must be FFFF, then rejected as not echo
		put(16'h0000, 1'b0, $urandom());
		put(16'h0000, 1'b0, $urandom());
		put(16'h0000, 1'b0, $urandom());
		put(16'h0000, 1'b0, $urandom());
		ship(1'b1, 16'h0000);
		// echo with zero id/seq: reply body all zero, patched checksum is 0000
		put(16'h0800, 1'b0, $urandom());
		put(16'h0000, 1'b0, $urandom());
		put(16'h0000, 1'b0, $urandom());
		put(16'h0000, 1'b0, $urandom());
		ship(1'b1, 16'h0000);

		// --- random messages ---
		// mostly well-formed echo requests with random content, then header
		// variants, corrupted checksums and unstructured noise
		while (words_sent < WORD_TARGET) begin
			kind = $urandom_range(0, 99);
			if (kind < 88) begin
				if (kind < 65) begin
					ty = ECHO_REQUEST_TYPE;
					cd = 8'h00;
				end else begin
					ty = $urandom_range(0, 1) ? ECHO_REQUEST_TYPE : 8'($urandom());
					cd = $urandom_range(0, 1) ? 8'h00 : 8'($urandom());
				end
				put({ty, cd}, 1'b0, $urandom());
				put(16'h0000, 1'b0, $urandom());
				put(16'($urandom()), 1'b0, $urandom());
				put(16'($urandom()), 1'b0, $urandom());
				plen = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40)
					: $urandom_range(0, 8);
				for (int i = 0; i < plen; i++) begin
					if (i == plen - 1) begin
						put(16'($urandom()), 1'($urandom_range(0, 1)), $urandom());
					end else begin
						put(16'($urandom()), $urandom_range(0, 15) == 0, $urandom());
					end
				end
				if (kind >= 78) begin
					ship(1'b1, 16'($urandom_range(1, 16'hFFFF)));
				end else begin
					ship(1'b1, 16'h0000);
				end
			end else begin
				plen = $urandom_range(1, 6);
				for (int i = 0; i < plen; i++) begin
					put(16'($urandom()), $urandom_range(0, 3) == 0, $urandom());
				end
				ship(1'($urandom_range(0, 1)), 16'h0000);
			end
		end

		// --- drain ---
		request_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0 && outstanding == 0) begin
			$display("icmp_echo_responder_top: match");
		end else begin
			$display("icmp_echo_responder_top: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
